// ===== rtl/gws_pkg.sv =====
// ----------------------------------------------------------------------------
// gws_pkg: shared definitions for the grid word search block
// Grid and pattern sizes, operation and direction codes, the control and
// status bundles between the search cells and the sequencer.
// ----------------------------------------------------------------------------
package gws_pkg;

  localparam int GRID_SIZE = 16;
  localparam int PAT_DEPTH = 16;
  localparam int IDX_W     = $clog2(GRID_SIZE);
  localparam int LEN_W     = 5;
  localparam int MAX_LEN   = (GRID_SIZE < PAT_DEPTH) ? GRID_SIZE : PAT_DEPTH;
  localparam int VEC_W     = MAX_LEN + 1;

  localparam logic [1:0] OP_LOAD_GRID = 2'd0;
  localparam logic [1:0] OP_LOAD_PAT  = 2'd1;
  localparam logic [1:0] OP_SEARCH    = 2'd2;

  localparam logic [2:0] DIR_RIGHT = 3'd0;
  localparam logic [2:0] DIR_LEFT  = 3'd1;
  localparam logic [2:0] DIR_DOWN  = 3'd2;
  localparam logic [2:0] DIR_UP    = 3'd3;
  localparam logic [2:0] DIR_DIAG  = 3'd4;

  typedef logic [PAT_DEPTH-1:0][7:0] pat_t;
  typedef logic [VEC_W-1:0]          run_vec_t;

  // Per-row control broadcast to every cell.
  typedef struct packed {
    logic             clear;
    logic             step;
    logic [IDX_W-1:0] row;
    logic [LEN_W-1:0] len;
  } cell_ctl_t;

  // What a cell reports back to the sequencer.
  typedef struct packed {
    logic [PAT_DEPTH-1:0] eq;
    logic                 diag_done;
    logic                 down_hit;
    logic [IDX_W-1:0]     down_row;
    logic                 up_hit;
    logic [IDX_W-1:0]     up_row;
  } cell_stat_t;

  // ASCII upper case is folded to lower case on every load.
  function automatic logic [7:0] fold_lower(input logic [7:0] ch);
    logic [7:0] res;
    res = ch;
    if (ch >= 8'h41 && ch <= 8'h5a) begin
      res = ch + 8'h20;
    end
    return res;
  endfunction

endpackage

// ===== rtl/gws_ram.sv =====
// ----------------------------------------------------------------------------
// gws_ram: generic single-port RAM
// One write or one read per cycle; the read data is registered.
// ----------------------------------------------------------------------------
module gws_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[addr] <= wdata;
    end
    rdata_r <= mem_r[addr];
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/gws_cell.sv =====
// ----------------------------------------------------------------------------
// gws_cell: one grid column of the search chain
// Compares the column's character of the current row against the pattern,
// tracks partial vertical runs, and passes its diagonal run to the next cell.
// ----------------------------------------------------------------------------
module gws_cell
  import gws_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  cell_ctl_t  ctl,
  input  logic [7:0] ch,
  input  pat_t       pat,
  input  run_vec_t   diag_in,
  output run_vec_t   diag_out,
  output cell_stat_t stat
);

  run_vec_t         down_r, down_nxt;
  run_vec_t         up_r, up_nxt;
  run_vec_t         diag_r, diag_nxt;
  logic             down_hit_r, up_hit_r;
  logic [IDX_W-1:0] down_row_r, up_row_r;
  logic [PAT_DEPTH-1:0] eq, eq_rev;
  logic [IDX_W-1:0] lm1;
  logic             len_ok, down_done, up_done, diag_done;

  assign lm1    = IDX_W'(ctl.len - LEN_W'(1));
  assign len_ok = (ctl.len != '0) && (ctl.len <= LEN_W'(MAX_LEN));

  always_comb begin
    for (int k = 0; k < PAT_DEPTH; k++) begin
      eq[k] = (ch == pat[k]);
    end
    // Upward runs meet the pattern from its last character backwards.
    for (int m = 0; m < PAT_DEPTH; m++) begin
      if (LEN_W'(m) < ctl.len) begin
        eq_rev[m] = eq[IDX_W'(ctl.len - LEN_W'(1) - LEN_W'(m))];
      end else begin
        eq_rev[m] = 1'b0;
      end
    end
    down_nxt    = '0;
    up_nxt      = '0;
    diag_nxt    = '0;
    down_nxt[0] = 1'b1;
    up_nxt[0]   = 1'b1;
    diag_nxt[0] = 1'b1;
    for (int k = 0; k < MAX_LEN; k++) begin
      down_nxt[k+1] = down_r[k] & eq[k];
      up_nxt[k+1]   = up_r[k] & eq_rev[k];
      diag_nxt[k+1] = diag_in[k] & eq[k];
    end
    down_done = len_ok && down_nxt[ctl.len];
    up_done   = len_ok && up_nxt[ctl.len];
    diag_done = len_ok && diag_nxt[ctl.len];
  end

  always_ff @(posedge clk) begin
    if (!rst_n || ctl.clear) begin
      down_r     <= run_vec_t'(1);
      up_r       <= run_vec_t'(1);
      diag_r     <= run_vec_t'(1);
      down_hit_r <= 1'b0;
      up_hit_r   <= 1'b0;
    end else if (ctl.step) begin
      down_r <= down_nxt;
      up_r   <= up_nxt;
      diag_r <= diag_nxt;
      // Downward: the earliest start row in this column wins.
      if (down_done && !down_hit_r) begin
        down_hit_r <= 1'b1;
        down_row_r <= ctl.row - lm1;
      end
      // Upward: the start is the bottom row, so the latest one wins.
      if (up_done) begin
        up_hit_r <= 1'b1;
        up_row_r <= ctl.row;
      end
    end
  end

  assign diag_out       = diag_r;
  assign stat.eq        = eq;
  assign stat.diag_done = diag_done;
  assign stat.down_hit  = down_hit_r;
  assign stat.down_row  = down_row_r;
  assign stat.up_hit    = up_hit_r;
  assign stat.up_row    = up_row_r;

endmodule

// ===== rtl/grid_word_search.sv =====
// ----------------------------------------------------------------------------
// grid_word_search: character grid with pattern search in five directions
// Holds a square grid and a pattern word and finds the pattern along rows,
// columns or the down-right diagonal.
// ----------------------------------------------------------------------------
// Usage. Items enter on the in_ channel (valid/stall). A grid load or a
// pattern load gives no result; letters A-Z are stored in lower case.
// A search item gives exactly one result item on the out_ channel: found
// flag plus the start row and column of the first match in the scan order
// of the chosen direction (0,0 when nothing matched).
// The grid must be fully loaded before a search is issued.
// Timing. A search streams the grid one row per cycle out of sixteen
// column memories into a chain of sixteen column cells. It occupies the
// block through the row reads, a drain step for the last read data, and a
// finishing step that picks the result and moves it into the output
// register. in_stall is high for the whole search; loads run at one per
// cycle while no search is in progress.
// A finished result sits in the output register while new loads are
// taken. If the receiver stalls and another search finishes, that search
// waits in its last step, with in_stall held, until the register frees.
// Reset. rst_n (synchronous) returns the sequencer to idle and empties the
// output register; the grid and pattern contents are not cleared.
// ----------------------------------------------------------------------------
module grid_word_search
  import gws_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [1:0]       in_operation,
  input  logic [7:0]       in_char_value,
  input  logic [3:0]       in_cell_row,
  input  logic [3:0]       in_cell_col,
  input  logic [3:0]       in_pattern_pos,
  input  logic [2:0]       in_direction,
  input  logic [LEN_W-1:0] in_word_length,
  output logic             out_valid,
  input  logic             out_stall,
  output logic             out_found,
  output logic [3:0]       out_match_row,
  output logic [3:0]       out_match_col
);

  typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_DRAIN, ST_FINISH} state_t;

  state_t           state_r, state_nxt;
  logic [IDX_W-1:0] rd_cnt_r, rd_cnt_nxt;
  logic             step_r, step_nxt;
  logic [IDX_W-1:0] step_row_r, step_row_nxt;
  logic [2:0]       dir_r, dir_nxt;
  logic [LEN_W-1:0] len_r, len_nxt;
  logic             hit_r, hit_nxt;
  logic [IDX_W-1:0] hit_row_r, hit_row_nxt, hit_col_r, hit_col_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             out_found_r, out_found_nxt;
  logic [3:0]       out_row_r, out_row_nxt, out_col_r, out_col_nxt;
  pat_t             pat_r;

  logic             in_acc, search_acc;
  logic [7:0]       folded;
  logic [IDX_W-1:0] ram_addr;
  logic [7:0]       row_ch [GRID_SIZE];
  cell_ctl_t        ctl;
  cell_stat_t       stat [GRID_SIZE];
  run_vec_t         diag_link [GRID_SIZE+1];
  logic [IDX_W-1:0] lm1;

  logic             cand_found;
  logic [IDX_W-1:0] cand_row, cand_col;
  logic             res_found;
  logic [IDX_W-1:0] res_row, res_col;

  assign in_stall   = (state_r != ST_IDLE);
  assign in_acc     = in_valid && !in_stall;
  assign search_acc = in_acc && (in_operation == OP_SEARCH);
  assign folded     = fold_lower(in_char_value);
  assign lm1        = IDX_W'(len_r - LEN_W'(1));

  // Reads follow the scan counter; writes only happen while idle.
  assign ram_addr = (state_r == ST_IDLE) ? in_cell_row : rd_cnt_r;

  assign ctl.clear = search_acc;
  assign ctl.step  = step_r;
  assign ctl.row   = step_row_r;
  assign ctl.len   = len_r;

  // Nothing lies to the left of column zero but the empty prefix.
  assign diag_link[0] = run_vec_t'(1);

  for (genvar c = 0; c < GRID_SIZE; c++) begin : g_col
    gws_ram #(
      .WIDTH (8),
      .DEPTH (GRID_SIZE)
    ) u_ram (
      .clk   (clk),
      .we    (in_acc && (in_operation == OP_LOAD_GRID) && (in_cell_col == IDX_W'(c))),
      .addr  (ram_addr),
      .wdata (folded),
      .rdata (row_ch[c])
    );

    gws_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctl      (ctl),
      .ch       (row_ch[c]),
      .pat      (pat_r),
      .diag_in  (diag_link[c]),
      .diag_out (diag_link[c+1]),
      .stat     (stat[c])
    );
  end

  // Pattern characters live in plain registers; each cell sees all of them.
  always_ff @(posedge clk) begin
    if (in_acc && (in_operation == OP_LOAD_PAT)) begin
      pat_r[in_pattern_pos] <= folded;
    end
  end

  // Match candidates within the row now on the cell inputs. Horizontal runs
  // are checked across the row at once; diagonal runs finish inside cells.
  always_comb begin
    logic rs;
    cand_found = 1'b0;
    cand_row   = step_row_r;
    cand_col   = '0;
    case (dir_r)
      DIR_RIGHT: begin
        for (int j = GRID_SIZE - 1; j >= 0; j--) begin
          rs = 1'b1;
          for (int k = 0; k < PAT_DEPTH; k++) begin
            if (LEN_W'(k) < len_r) begin
              if (j + k < GRID_SIZE) begin
                rs &= stat[(j + k) % GRID_SIZE].eq[k];
              end else begin
                rs = 1'b0;
              end
            end
          end
          if (rs) begin
            cand_found = 1'b1;
            cand_col   = IDX_W'(j);
          end
        end
      end
      DIR_LEFT: begin
        for (int j = 0; j < GRID_SIZE; j++) begin
          rs = 1'b1;
          for (int k = 0; k < PAT_DEPTH; k++) begin
            if (LEN_W'(k) < len_r) begin
              if (j >= k) begin
                rs &= stat[(j - k + GRID_SIZE) % GRID_SIZE].eq[k];
              end else begin
                rs = 1'b0;
              end
            end
          end
          if (rs) begin
            cand_found = 1'b1;
            cand_col   = IDX_W'(j);
          end
        end
      end
      DIR_DIAG: begin
        cand_row = step_row_r - lm1;
        for (int c = GRID_SIZE - 1; c >= 0; c--) begin
          if (stat[c].diag_done) begin
            cand_found = 1'b1;
            cand_col   = IDX_W'(c) - lm1;
          end
        end
      end
      default: begin
      end
    endcase
  end

  // Final answer once all rows have passed through the chain.
  always_comb begin
    res_found = 1'b0;
    res_row   = '0;
    res_col   = '0;
    if (len_r == '0) begin
      // An empty word matches at the first start of the scan.
      case (dir_r)
        DIR_RIGHT, DIR_DOWN, DIR_DIAG: begin
          res_found = 1'b1;
        end
        DIR_LEFT: begin
          res_found = 1'b1;
          res_col   = IDX_W'(GRID_SIZE - 1);
        end
        DIR_UP: begin
          res_found = 1'b1;
          res_row   = IDX_W'(GRID_SIZE - 1);
        end
        default: begin
        end
      endcase
    end else if (len_r <= LEN_W'(MAX_LEN)) begin
      case (dir_r)
        DIR_RIGHT, DIR_LEFT, DIR_DIAG: begin
          res_found = hit_r;
          if (hit_r) begin
            res_row = hit_row_r;
            res_col = hit_col_r;
          end
        end
        DIR_DOWN: begin
          for (int c = GRID_SIZE - 1; c >= 0; c--) begin
            if (stat[c].down_hit) begin
              res_found = 1'b1;
              res_row   = stat[c].down_row;
              res_col   = IDX_W'(c);
            end
          end
        end
        DIR_UP: begin
          for (int c = GRID_SIZE - 1; c >= 0; c--) begin
            if (stat[c].up_hit) begin
              res_found = 1'b1;
              res_row   = stat[c].up_row;
              res_col   = IDX_W'(c);
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Sequencer: idle, stream rows, finish the last row, hand off the result.
  always_comb begin
    state_nxt     = state_r;
    rd_cnt_nxt    = rd_cnt_r;
    step_nxt      = 1'b0;
    step_row_nxt  = step_row_r;
    dir_nxt       = dir_r;
    len_nxt       = len_r;
    hit_nxt       = hit_r;
    hit_row_nxt   = hit_row_r;
    hit_col_nxt   = hit_col_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_found_nxt = out_found_r;
    out_row_nxt   = out_row_r;
    out_col_nxt   = out_col_r;

    if (step_r && cand_found && !hit_r) begin
      hit_nxt     = 1'b1;
      hit_row_nxt = cand_row;
      hit_col_nxt = cand_col;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (search_acc) begin
          state_nxt  = ST_SCAN;
          rd_cnt_nxt = '0;
          dir_nxt    = in_direction;
          len_nxt    = in_word_length;
          hit_nxt    = 1'b0;
        end
      end
      ST_SCAN: begin
        step_nxt     = 1'b1;
        step_row_nxt = rd_cnt_r;
        rd_cnt_nxt   = rd_cnt_r + IDX_W'(1);
        if (rd_cnt_r == IDX_W'(GRID_SIZE - 1)) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_nxt = ST_FINISH;
      end
      ST_FINISH: begin
        if (!out_valid_r || !out_stall) begin
          state_nxt     = ST_IDLE;
          out_valid_nxt = 1'b1;
          out_found_nxt = res_found;
          out_row_nxt   = res_row;
          out_col_nxt   = res_col;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      step_r      <= 1'b0;
      hit_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      hit_r       <= hit_nxt;
      out_valid_r <= out_valid_nxt;
    end
    rd_cnt_r    <= rd_cnt_nxt;
    step_row_r  <= step_row_nxt;
    dir_r       <= dir_nxt;
    len_r       <= len_nxt;
    hit_row_r   <= hit_row_nxt;
    hit_col_r   <= hit_col_nxt;
    out_found_r <= out_found_nxt;
    out_row_r   <= out_row_nxt;
    out_col_r   <= out_col_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_found     = out_found_r;
  assign out_match_row = out_row_r;
  assign out_match_col = out_col_r;

  // A new result only ever comes out of the finishing step.
  a_result_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_FINISH))
    else $error("result appeared outside the finishing step");

  // Row data is processed only while the scan or its drain is running.
  a_step_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    step_r |-> (state_r == ST_SCAN) || (state_r == ST_DRAIN))
    else $error("row step outside a scan");

  // A miss always reports position zero.
  a_miss_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_found_r) |-> (out_row_r == '0) && (out_col_r == '0))
    else $error("miss with nonzero position");

  // The scan counter wraps exactly when the drain step begins.
  a_drain_after_last_row: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DRAIN) |-> step_r && (step_row_r == IDX_W'(GRID_SIZE - 1)))
    else $error("drain step without the last row");

endmodule

// ===== test/grid_word_search_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// grid_word_search_test: self-checking bench for the grid word search block
// Loads the grid and pattern, then runs directed and random searches in all
// directions with random gaps and stalls on both channels. Every search
// result is compared with an in-bench prediction of the first match.
// ----------------------------------------------------------------------------

// Holds the predicted search results in order and checks the block's output.
class search_scoreboard;
  logic [7:0] grid_chars[16][16];
  logic [7:0] word_chars[16];
  logic [8:0] pending_results[$];
  int errors;
  int searches;
  int hits;

  function logic [7:0] lower(logic [7:0] ch);
    return (ch >= 8'h41 && ch <= 8'h5a) ? ch + 8'h20 : ch;
  endfunction

  function bit run_ok(int r, int c, int dr, int dc, int len);
    for (int k = 0; k < len; k++) begin
      if (word_chars[k] != grid_chars[r + dr * k][c + dc * k]) return 0;
    end
    return 1;
  endfunction

  // Returns {found, row, col} for the first start in the direction's scan order.
  function logic [8:0] find_word(logic [2:0] dir, int len);
    if (len > 16) return '0;
    for (int i = 0; i < 16; i++) begin
      for (int j = 0; j < 16; j++) begin
        case (dir)
          gws_pkg::DIR_RIGHT: begin
            if (j <= 16 - len && run_ok(i, j, 0, 1, len)) return {1'b1, 4'(i), 4'(j)};
          end
          gws_pkg::DIR_LEFT: begin
            if (15 - j >= len - 1 && run_ok(i, 15 - j, 0, -1, len))
              return {1'b1, 4'(i), 4'(15 - j)};
          end
          gws_pkg::DIR_DOWN: begin
            if (j <= 16 - len && run_ok(j, i, 1, 0, len)) return {1'b1, 4'(j), 4'(i)};
          end
          gws_pkg::DIR_UP: begin
            if (15 - j >= len - 1 && run_ok(15 - j, i, -1, 0, len))
              return {1'b1, 4'(15 - j), 4'(i)};
          end
          gws_pkg::DIR_DIAG: begin
            if (i <= 16 - len && j <= 16 - len && run_ok(i, j, 1, 1, len))
              return {1'b1, 4'(i), 4'(j)};
          end
          default: return '0;
        endcase
      end
    end
    return '0;
  endfunction

  function void note_item(logic [1:0] op, logic [7:0] ch, logic [3:0] r, logic [3:0] c,
                          logic [3:0] p, logic [2:0] dir, logic [4:0] len);
    case (op)
      gws_pkg::OP_LOAD_GRID: grid_chars[r][c] = lower(ch);
      gws_pkg::OP_LOAD_PAT: word_chars[p] = lower(ch);
      gws_pkg::OP_SEARCH: begin
        pending_results.push_back(find_word(dir, len));
        searches++;
      end
      default: ;
    endcase
  endfunction

  task report_bad(string msg);
    errors++;
    if (errors <= 30) $display("MISMATCH at %0t: %s", $realtime, msg);
  endtask

  task check_result(logic found, logic [3:0] r, logic [3:0] c);
    logic [8:0] want;
    if (pending_results.size() == 0) begin
      report_bad($sformatf("unexpected result %0d/%0d/%0d", found, r, c));
      return;
    end
    want = pending_results.pop_front();
    hits += found;
    if (found !== want[8]) report_bad($sformatf("found %0d want %0d", found, want[8]));
    if (r !== want[7:4]) report_bad($sformatf("row %0d want %0d", r, want[7:4]));
    if (c !== want[3:0]) report_bad($sformatf("col %0d want %0d", c, want[3:0]));
  endtask
endclass

module grid_word_search_test;
  import gws_pkg::*;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  logic [1:0] in_operation;
  logic [7:0] in_char_value;
  logic [3:0] in_cell_row;
  logic [3:0] in_cell_col;
  logic [3:0] in_pattern_pos;
  logic [2:0] in_direction;
  logic [LEN_W-1:0] in_word_length;
  logic out_valid;
  logic out_stall;
  logic out_found;
  logic [3:0] out_match_row;
  logic [3:0] out_match_col;

  search_scoreboard board;
  int items_sent;
  // While set, the receiver holds off to let the block back up.
  bit hold_results;
  // Small alphabet so that random words actually occur in the grid.
  logic [7:0] letters[4] = '{8'h61, 8'h42, 8'h63, 8'h44};

  grid_word_search dut (.*);

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  initial begin
    #4000000;
    $display("FAILURE");
    $finish;
  end

  // Most gaps are short; a few are long.
  function int gap_len();
    int roll;
    roll = $urandom_range(99);
    if (roll < 55) return 0;
    if (roll < 92) return $urandom_range(3, 1);
    return $urandom_range(30, 8);
  endfunction

  // Offers one item and waits until the block accepts it; the payload stays put while stalled.
  task send_item(logic [1:0] op, logic [7:0] ch, logic [3:0] r, logic [3:0] c,
                 logic [3:0] p, logic [2:0] dir, logic [4:0] len);
    int idle;
    idle = gap_len();
    if (idle > 0) begin
      in_valid <= 1'b0;
      repeat (idle) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_operation <= op;
    in_char_value <= ch;
    in_cell_row <= r;
    in_cell_col <= c;
    in_pattern_pos <= p;
    in_direction <= dir;
    in_word_length <= len;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    board.note_item(op, ch, r, c, p, dir, len);
    items_sent++;
  endtask

  task load_cell(int r, int c, logic [7:0] ch);
    send_item(OP_LOAD_GRID, ch, 4'(r), 4'(c), 4'($urandom), 3'($urandom), 5'($urandom));
  endtask

  task load_char(int p, logic [7:0] ch);
    send_item(OP_LOAD_PAT, ch, 4'($urandom), 4'($urandom), 4'(p), 3'($urandom),
              5'($urandom));
  endtask

  task search_for(logic [2:0] dir, logic [4:0] len);
    send_item(OP_SEARCH, 8'($urandom), 4'($urandom), 4'($urandom), 4'($urandom), dir, len);
  endtask

  task wait_drained();
    in_valid <= 1'b0;
    while (board.pending_results.size() != 0) @(posedge clk);
    repeat (25) @(posedge clk);
  endtask

  // Plants the current pattern along a random direction at a legal start.
  task plant_word(int len);
    int dir;
    int r;
    int c;
    dir = $urandom_range(4);
    r = $urandom_range(15);
    c = $urandom_range(15);
    if (dir == DIR_RIGHT || dir == DIR_DIAG) c = $urandom_range(16 - len);
    if (dir == DIR_LEFT) c = $urandom_range(15, len - 1);
    if (dir == DIR_DOWN || dir == DIR_DIAG) r = $urandom_range(16 - len);
    if (dir == DIR_UP) r = $urandom_range(15, len - 1);
    for (int k = 0; k < len; k++) begin
      load_cell(r, c, board.word_chars[k] ^ ((k % 3 == 0) ? 8'h20 : 8'h00));
      case (dir)
        DIR_RIGHT: c++;
        DIR_LEFT: c--;
        DIR_DOWN: r++;
        DIR_UP: r--;
        default: begin
          r++;
          c++;
        end
      endcase
    end
  endtask

  // Receiver: random stalls, with one long hold-off requested by the sender.
  initial begin
    out_stall <= 1'b1;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (hold_results) out_stall <= 1'b1;
      else out_stall <= ($urandom_range(99) < 20) || ($urandom_range(99) < 2 && !out_stall);
    end
  end

  // Result monitor sees the values from before the edge, so ordering within a step does not matter.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) board.check_result(out_found, out_match_row,
                                                            out_match_col);
  end

  initial begin
    int len;
    int roll;
    board = new();
    for (int i = 0; i < 16; i++) begin
      for (int j = 0; j < 16; j++) board.grid_chars[i][j] = 'x;
      board.word_chars[i] = 'x;
    end
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_operation <= OP_LOAD_GRID;
    in_char_value <= '0;
    in_cell_row <= '0;
    in_cell_col <= '0;
    in_pattern_pos <= '0;
    in_direction <= DIR_RIGHT;
    in_word_length <= '0;
    hold_results = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // The whole grid and pattern are written before any search; char byte extremes follow.
    for (int i = 0; i < 16; i++) begin
      for (int j = 0; j < 16; j++) load_cell(i, j, letters[$urandom_range(3)]);
    end
    for (int p = 0; p < 16; p++) load_char(p, letters[$urandom_range(3)]);

    // Directed: every direction at zero length, full length, too long, bad directions.
    load_cell(0, 0, 8'hff);
    load_cell(15, 15, 8'h00);
    load_char(0, 8'h5a);
    load_char(1, 8'h40);
    for (int d = 0; d < 5; d++) search_for(3'(d), 5'd0);
    search_for(DIR_RIGHT, 5'd16);
    search_for(DIR_DIAG, 5'd16);
    search_for(DIR_UP, 5'd17);
    search_for(DIR_LEFT, 5'd31);
    search_for(3'd5, 5'd1);
    search_for(3'd7, 5'd0);
    send_item(2'd3, 8'hff, 4'hf, 4'hf, 4'hf, 3'd7, 5'd31);
    load_char(0, 8'h61);
    search_for(DIR_DOWN, 5'd1);
    search_for(DIR_UP, 5'd1);
    search_for(DIR_LEFT, 5'd1);

    // Long receiver hold-off while the sender keeps offering, so the block backs up.
    fork
      begin
        hold_results = 1;
        repeat (300) @(posedge clk);
        hold_results = 0;
      end
      for (int n = 0; n < 6; n++) search_for(3'($urandom_range(4)), 5'($urandom_range(3)));
    join
    wait_drained();

    // Random part: mostly new words planted in the grid and searched for.
    while (items_sent < 1050) begin
      roll = $urandom_range(99);
      if (roll < 35) begin
        len = $urandom_range(99) < 85 ? $urandom_range(5, 1) : $urandom_range(16, 6);
        for (int p = 0; p < len; p++) load_char(p, letters[$urandom_range(3)]);
        plant_word(len);
        for (int d = 0; d < 5; d++) search_for(3'(d), 5'(len));
      end else if (roll < 55) begin
        search_for(3'($urandom_range(7)), 5'($urandom_range(99) < 90 ?
                   $urandom_range(4) : $urandom_range(31)));
      end else if (roll < 80) begin
        load_cell($urandom_range(15), $urandom_range(15),
                  $urandom_range(3) == 0 ? 8'($urandom) : letters[$urandom_range(3)]);
      end else if (roll < 90) begin
        load_char($urandom_range(15), $urandom_range(3) == 0 ? 8'($urandom) :
                  letters[$urandom_range(3)]);
      end else if (roll < 95) begin
        send_item(2'd3, 8'($urandom), 4'($urandom), 4'($urandom), 4'($urandom),
                  3'($urandom), 5'($urandom));
      end else begin
        wait_drained();
      end
    end

    wait_drained();
    $display("Ran %0d items: %0d searches checked, %0d found a word.", items_sent,
             board.searches, board.hits);
    if (board.errors == 0 && board.pending_results.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/gws_pkg.sv
rtl/gws_ram.sv
rtl/gws_cell.sv
rtl/grid_word_search.sv
test/grid_word_search_test.sv
